// ===== hdl/sdf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sdf_pkg
// shared types and constants of the signed decimal formatter
// ----------------------------------------------------------------------------
package sdf_pkg;

   localparam int VALUE_W       = 64;
   localparam int NUM_DIGITS    = 19;
   localparam int BCD_W         = 4 * NUM_DIGITS;
   localparam int BITS_PER_STEP = 4;
   localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
   localparam int STEP_CNT_W    = $clog2(CONV_STEPS);
   localparam int ND_W          = $clog2(NUM_DIGITS + 1);
   localparam int CNT_W         = 7;
   localparam int MAX_CHARS_DEF = 64;

   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_SHORT  = 2'd1;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_NORM,
      ST_SETUP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic shift;
   } digit_cmd_type;

endpackage
`default_nettype wire

// ===== hdl/sdf_digit_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sdf_digit_unit
// shift-and-add-3 binary to bcd converter, four bits per step, with a
// nibble shifter that walks the digits out from the most significant end
// ----------------------------------------------------------------------------
module sdf_digit_unit (
   input  wire                          clock,
   input  wire sdf_pkg::digit_cmd_type  cmd,
   input  wire [sdf_pkg::VALUE_W-1:0]   load_value,
   output logic [3:0]                   top_digit
);
   import sdf_pkg::*;

   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [VALUE_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]   bcd_step;
   logic [VALUE_W-1:0] bin_step;

   always_comb begin
      bcd_step = bcd_ff;
      bin_step = bin_ff;
      for (int s = 0; s < BITS_PER_STEP; s++) begin
         for (int d = 0; d < NUM_DIGITS; d++) begin
            if (bcd_step[d*4 +: 4] >= 4'd5) begin
               bcd_step[d*4 +: 4] = bcd_step[d*4 +: 4] + 4'd3;
            end
         end
         {bcd_step, bin_step} = {bcd_step[BCD_W-2:0], bin_step, 1'b0};
      end
   end

   always_comb begin
      bcd_in = bcd_ff;
      bin_in = bin_ff;
      if (cmd.load) begin
         bcd_in = '0;
         bin_in = load_value;
      end else if (cmd.step) begin
         bcd_in = bcd_step;
         bin_in = bin_step;
      end else if (cmd.shift) begin
         bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
      end
   end

   always_ff @(posedge clock) begin
      bcd_ff <= bcd_in;
      bin_ff <= bin_in;
   end

   assign top_digit = bcd_ff[BCD_W-1 -: 4];

endmodule
`default_nettype wire

// ===== hdl/signed_decimal_formatter_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// signed_decimal_formatter_top
// printf style %d conversion of one signed integer into ascii characters
// ----------------------------------------------------------------------------
// One item is accepted in the idle state, converted in the shared bcd
// converter (four bits of the magnitude a cycle), stripped of leading zero
// digits in the same unit's nibble shifter (one digit a cycle, at most 18),
// passed through a setup state, then sent one character per cycle while
// the sink is ready, and followed by one closing state in which the block
// is still busy. The input is not ready until the last character has been
// handed to the output register.
// ----------------------------------------------------------------------------
module signed_decimal_formatter_top #(
   parameter int MAX_CHARS = sdf_pkg::MAX_CHARS_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // value[63:0], length_mode[65:64], precision_given[66], min_digits[72:67],
   // force_sign[73], sign_char[81:74], field_width[88:82], left_justify[89]
   input  wire [95:0]  req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // out_char[7:0]
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast
);
   import sdf_pkg::*;

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CHARS);

   state_type state_ff, state_in;

   logic [STEP_CNT_W-1:0] step_cnt_ff, step_cnt_in;
   logic [ND_W-1:0]       nd_ff, nd_in;
   logic                  sign_pend_ff, sign_pend_in;
   logic [7:0]            sign_chr_ff, sign_chr_in;
   logic [5:0]            prec_ff, prec_in;
   logic [CNT_W-1:0]      width_ff, width_in;
   logic                  left_ff, left_in;
   logic                  zero_case_ff, zero_case_in;
   logic [CNT_W-1:0]      padl_ff, padl_in;
   logic [CNT_W-1:0]      padr_ff, padr_in;
   logic [5:0]            zero_cnt_ff, zero_cnt_in;
   logic [ND_W-1:0]       dig_cnt_ff, dig_cnt_in;
   logic [CNT_W-1:0]      total_ff, total_in;
   logic [CNT_W-1:0]      emitted_ff, emitted_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;

   digit_cmd_type   cmd;
   logic [3:0]      top_digit;
   logic [63:0]     in_value;
   logic [1:0]      in_mode;
   logic [63:0]     kept;
   logic [63:0]     mag;
   logic [5:0]      in_prec;
   logic            accept;
   logic            can_emit;
   logic            emit_done;
   logic            norm_more;
   logic [ND_W-1:0] nd_eff;
   logic [5:0]      zeros;
   logic [CNT_W-1:0] nb;
   logic [CNT_W-1:0] pad;
   logic [CNT_W-1:0] n_chars;

   assign in_value = req_tdata[63:0];
   assign in_mode  = req_tdata[65:64];
   assign in_prec  = req_tdata[66] ? req_tdata[72:67] : 6'd1;
   assign accept   = req_tvalid & req_tready;

   always_comb begin
      unique case (in_mode)
         MODE_NORMAL: kept = {{32{in_value[31]}}, in_value[31:0]};
         MODE_SHORT:  kept = {{48{in_value[15]}}, in_value[15:0]};
         default:     kept = in_value;
      endcase
   end

   assign mag = kept[63] ? (64'd0 - kept) : kept;

   assign can_emit  = ~rsp_valid_ff | rsp_tready;
   assign emit_done = (emitted_ff == total_ff);
   assign norm_more = (top_digit == 4'd0) && (nd_ff > ND_W'(1));

   // setup arithmetic
   always_comb begin
      nd_eff  = zero_case_ff ? '0 : nd_ff;
      zeros   = (prec_ff > 6'(nd_eff)) ? (prec_ff - 6'(nd_eff)) : '0;
      nb      = CNT_W'(sign_pend_ff) + CNT_W'(zeros) + CNT_W'(nd_eff);
      pad     = (width_ff > nb) ? (width_ff - nb) : '0;
      n_chars = (width_ff > nb) ? width_ff : nb;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (accept) state_in = ST_CONVERT;
         ST_CONVERT: if (step_cnt_ff == STEP_CNT_W'(CONV_STEPS - 1)) state_in = ST_NORM;
         ST_NORM:    if (!norm_more) state_in = ST_SETUP;
         ST_SETUP:   state_in = ST_EMIT;
         ST_EMIT:    if (emit_done) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd          = '0;
      req_tready   = 1'b0;
      step_cnt_in  = step_cnt_ff;
      nd_in        = nd_ff;
      sign_pend_in = sign_pend_ff;
      sign_chr_in  = sign_chr_ff;
      prec_in      = prec_ff;
      width_in     = width_ff;
      left_in      = left_ff;
      zero_case_in = zero_case_ff;
      padl_in      = padl_ff;
      padr_in      = padr_ff;
      zero_cnt_in  = zero_cnt_ff;
      dig_cnt_in   = dig_cnt_ff;
      total_in     = total_ff;
      emitted_in   = emitted_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               cmd.load     = 1'b1;
               step_cnt_in  = '0;
               nd_in        = ND_W'(NUM_DIGITS);
               sign_pend_in = kept[63] | req_tdata[73];
               sign_chr_in  = kept[63] ? CHAR_MINUS : req_tdata[81:74];
               prec_in      = in_prec;
               width_in     = req_tdata[88:82];
               left_in      = req_tdata[89];
               zero_case_in = (mag == 64'd0) && (in_prec == 6'd0);
            end
         end
         ST_CONVERT: begin
            cmd.step    = 1'b1;
            step_cnt_in = step_cnt_ff + STEP_CNT_W'(1);
         end
         ST_NORM: begin
            if (norm_more) begin
               cmd.shift = 1'b1;
               nd_in     = nd_ff - ND_W'(1);
            end
         end
         ST_SETUP: begin
            zero_cnt_in = zeros;
            dig_cnt_in  = nd_eff;
            padl_in     = left_ff ? '0 : pad;
            padr_in     = left_ff ? pad : '0;
            total_in    = (n_chars > MAX_CNT) ? MAX_CNT : n_chars;
            emitted_in  = '0;
         end
         ST_EMIT: begin
            if (!emit_done && can_emit) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = (emitted_ff + CNT_W'(1) == total_ff);
               emitted_in   = emitted_ff + CNT_W'(1);
               if (padl_ff != '0) begin
                  rsp_data_in = CHAR_SPACE;
                  padl_in     = padl_ff - CNT_W'(1);
               end else if (sign_pend_ff) begin
                  rsp_data_in  = sign_chr_ff;
                  sign_pend_in = 1'b0;
               end else if (zero_cnt_ff != '0) begin
                  rsp_data_in = CHAR_ZERO;
                  zero_cnt_in = zero_cnt_ff - 6'd1;
               end else if (dig_cnt_ff != '0) begin
                  rsp_data_in = CHAR_ZERO | {4'd0, top_digit};
                  dig_cnt_in  = dig_cnt_ff - ND_W'(1);
                  cmd.shift   = 1'b1;
               end else begin
                  rsp_data_in = CHAR_SPACE;
                  padr_in     = padr_ff - CNT_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_cnt_ff  <= step_cnt_in;
      nd_ff        <= nd_in;
      sign_pend_ff <= sign_pend_in;
      sign_chr_ff  <= sign_chr_in;
      prec_ff      <= prec_in;
      width_ff     <= width_in;
      left_ff      <= left_in;
      zero_case_ff <= zero_case_in;
      padl_ff      <= padl_in;
      padr_ff      <= padr_in;
      zero_cnt_ff  <= zero_cnt_in;
      dig_cnt_ff   <= dig_cnt_in;
      total_ff     <= total_in;
      emitted_ff   <= emitted_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
   end

   sdf_digit_unit u_digit (
      .clock      (clock),
      .cmd        (cmd),
      .load_value (mag),
      .top_digit  (top_digit)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

// ===== test/sdf_char_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_char_checker
// watches both channels of the signed decimal formatter and checks each
// character
// ----------------------------------------------------------------------------
// Every accepted request is formatted here the way printf prints %d, cut to
// MAX_CHARS. Characters are queued, and each one leaving the block is compared
// with the oldest queued one, on both the character and the end mark.
// ----------------------------------------------------------------------------
module sdf_char_checker #(
   parameter int MAX_CHARS = sdf_pkg::MAX_CHARS_DEF
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   input  wire        req_tready,
   input  wire [95:0] req_tdata,
   input  wire        rsp_tvalid,
   input  wire        rsp_tready,
   input  wire [7:0]  rsp_tdata,
   input  wire        rsp_tlast,
   output int         mismatch_count,
   output int         chars_pending
);
   import sdf_pkg::*;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } char_type;

   char_type expected_chars[$];
   int       char_count;

   initial begin
      mismatch_count = 0;
      chars_pending  = 0;
      char_count     = 0;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] character %0d: %s", $time, char_count, what);
      mismatch_count++;
   endtask

   function automatic void format_decimal(input logic [95:0] req);
      logic [63:0] raw;
      logic [63:0] v;
      logic [63:0] mag;
      logic [63:0] m;
      logic        neg;
      logic        fsign;
      logic        left;
      logic [7:0]  schar;
      logic [6:0]  prec;
      logic [6:0]  width;
      logic [7:0]  digit_chars[$];
      logic [7:0]  body[$];
      logic [7:0]  chars_out[$];
      int          pad;
      int          emit;
      int          i;
      raw = req[63:0];
      case (req[65:64])
         MODE_NORMAL: begin
            v = {{32{raw[31]}}, raw[31:0]};
         end
         MODE_SHORT: begin
            v = {{48{raw[15]}}, raw[15:0]};
         end
         default: begin
            v = raw;
         end
      endcase
      neg   = v[63];
      mag   = neg ? -v : v;
      prec  = req[66] ? {1'b0, req[72:67]} : 7'd1;
      fsign = req[73];
      schar = req[81:74];
      width = req[88:82];
      left  = req[89];

      // zero at precision zero prints no digits
      if (mag != 64'd0 || prec != 7'd0) begin
         m = mag;
         do begin
            digit_chars.push_front(CHAR_ZERO + 8'(m % 64'd10));
            m = m / 64'd10;
         end while (m != 64'd0);
      end

      if (neg) begin
         body.push_back(CHAR_MINUS);
      end else if (fsign) begin
         body.push_back(schar);
      end
      for (i = digit_chars.size(); i < int'(prec); i++) begin
         body.push_back(CHAR_ZERO);
      end
      foreach (digit_chars[k]) begin
         body.push_back(digit_chars[k]);
      end

      pad = (int'(width) > body.size()) ? int'(width) - body.size() : 0;
      if (!left) begin
         repeat (pad) chars_out.push_back(CHAR_SPACE);
      end
      foreach (body[k]) begin
         chars_out.push_back(body[k]);
      end
      if (left) begin
         repeat (pad) chars_out.push_back(CHAR_SPACE);
      end

      emit = (chars_out.size() < MAX_CHARS) ? chars_out.size() : MAX_CHARS;
      for (i = 0; i < emit; i++) begin
         expected_chars.push_back('{ch: chars_out[i], last: (i == emit - 1)});
      end
   endfunction

   always @(posedge clock) begin
      char_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected char %02h", rsp_tdata));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_tdata !== want.ch) begin
                  report_mismatch($sformatf("out_char %02h, expected %02h",
                                            rsp_tdata, want.ch));
               end
               if (rsp_tlast !== want.last) begin
                  report_mismatch($sformatf("last_char %b, expected %b",
                                            rsp_tlast, want.last));
               end
            end
            char_count++;
         end
         if (req_tvalid && req_tready) begin
            format_decimal(req_tdata);
         end
      end
      chars_pending <= expected_chars.size();
   end

endmodule

// ===== test/tb_signed_decimal_formatter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_decimal_formatter_top
// testbench of the signed decimal formatter
// ----------------------------------------------------------------------------
// Sends a directed set of conversions (extremes of value, length modes,
// precision, sign and width, truncated output) and then random ones, with
// random gaps on the request side and random stalls on the character side.
// The checker beside the block predicts every character and counts mismatches.
// ----------------------------------------------------------------------------
module tb_signed_decimal_formatter_top;

   localparam int          RANDOM_ITEMS = 320;
   localparam int          CYCLE_LIMIT  = 2000000;
   localparam int          TAIL_CYCLES  = 150;
   localparam logic [1:0]  MODE_NORMAL  = sdf_pkg::MODE_NORMAL;
   localparam logic [1:0]  MODE_SHORT   = sdf_pkg::MODE_SHORT;
   localparam logic [1:0]  MODE_LONG    = 2'd2;
   localparam logic [1:0]  MODE_SPARE   = 2'd3;
   localparam logic [7:0]  CHAR_PLUS    = 8'h2b;
   localparam logic [7:0]  CHAR_BLANK   = sdf_pkg::CHAR_SPACE;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   int          mismatch_count;
   int          chars_pending;
   int          cycle_count = 0;
   logic        src_steady  = 1'b0;
   logic        sink_steady = 1'b0;

   always #2 clock = ~clock;

   signed_decimal_formatter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   sdf_char_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .chars_pending  (chars_pending)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic send_conversion(input logic [63:0] value, input logic [1:0] mode,
                                  input logic pgiven, input logic [5:0] mdig,
                                  input logic fsign, input logic [7:0] schar,
                                  input logic [6:0] width, input logic left);
      int gap;
      gap = src_steady ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {6'd0, left, width, schar, fsign, mdig, pgiven, mode, value};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_random_conversion();
      logic [63:0] value;
      logic [5:0]  mdig;
      logic [6:0]  width;
      logic [7:0]  schar;
      int          pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         value = 64'd0;
      end else if (pick <= 3) begin
         value = 64'($urandom_range(0, 999));
         if ($urandom_range(0, 1)) value = -value;
      end else if (pick <= 5) begin
         // powers of two and their neighbors hit the sign boundaries
         value = 64'd1 << $urandom_range(0, 63);
         if ($urandom_range(0, 1)) value = value - 64'd1;
         if ($urandom_range(0, 1)) value = -value;
      end else begin
         value = {32'($urandom), 32'($urandom)};
      end
      mdig = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 12))
                                        : 6'($urandom_range(0, 63));
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         width = 7'($urandom_range(0, 24));
      end else if (pick < 9) begin
         width = 7'($urandom_range(0, 64));
      end else begin
         width = 7'($urandom_range(0, 127));
      end
      pick = $urandom_range(0, 2);
      schar = (pick == 0) ? CHAR_PLUS : (pick == 1) ? CHAR_BLANK : 8'($urandom);
      send_conversion(value, 2'($urandom_range(0, 3)), 1'($urandom), mdig,
                      1'($urandom), schar, width, 1'($urandom));
   endtask

   // character sink with random stalls
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = sink_steady ? 0 : $urandom_range(0, 10);
         if ($urandom_range(0, 39) == 0) sink_steady = !sink_steady;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero at precision zero, with and without sign and padding
      send_conversion(64'd0, MODE_NORMAL, 1'b1, 6'd0, 1'b0, CHAR_PLUS, 7'd0, 1'b0);
      send_conversion(64'd0, MODE_NORMAL, 1'b1, 6'd0, 1'b1, CHAR_PLUS, 7'd5, 1'b0);
      send_conversion(64'd0, MODE_NORMAL, 1'b1, 6'd0, 1'b0, CHAR_PLUS, 7'd3, 1'b1);
      send_conversion(64'd0, MODE_LONG, 1'b1, 6'd0, 1'b0, CHAR_PLUS, 7'd0, 1'b1);
      // length mode extremes
      send_conversion(64'h8000_0000_0000_0000, MODE_LONG, 1'b0, 6'h3f, 1'b1, CHAR_PLUS,
                      7'd0, 1'b0);
      send_conversion(64'h7fff_ffff_ffff_ffff, MODE_LONG, 1'b0, 6'd0, 1'b1, CHAR_BLANK,
                      7'd25, 1'b1);
      send_conversion(64'hdead_beef_8000_0000, MODE_NORMAL, 1'b0, 6'd0, 1'b0, CHAR_PLUS,
                      7'd0, 1'b0);
      send_conversion(64'h1234_5678_7fff_ffff, MODE_NORMAL, 1'b0, 6'd0, 1'b1, CHAR_PLUS,
                      7'd0, 1'b0);
      send_conversion(64'hffff_0000_ffff_8000, MODE_SHORT, 1'b1, 6'd8, 1'b0, CHAR_PLUS,
                      7'd12, 1'b0);
      send_conversion(64'h0000_0000_0000_7fff, MODE_SHORT, 1'b0, 6'd0, 1'b0, CHAR_PLUS,
                      7'd0, 1'b0);
      send_conversion(64'h8000_0000_0000_0000, MODE_SPARE, 1'b0, 6'd0, 1'b0, CHAR_PLUS,
                      7'd0, 1'b0);
      send_conversion(64'hffff_ffff_ffff_ffff, MODE_NORMAL, 1'b0, 6'd0, 1'b0, CHAR_PLUS,
                      7'd1, 1'b0);
      // long outputs, exact fit and cut
      send_conversion(-64'd1, MODE_LONG, 1'b1, 6'd62, 1'b1, CHAR_PLUS, 7'd0, 1'b0);
      send_conversion(64'd42, MODE_NORMAL, 1'b1, 6'd63, 1'b1, CHAR_PLUS, 7'd0, 1'b0);
      send_conversion(-64'd7, MODE_NORMAL, 1'b1, 6'd63, 1'b0, CHAR_PLUS, 7'd0, 1'b0);
      send_conversion(64'd5, MODE_NORMAL, 1'b0, 6'd0, 1'b0, CHAR_PLUS, 7'd127, 1'b0);
      send_conversion(64'd5, MODE_NORMAL, 1'b0, 6'd0, 1'b0, CHAR_PLUS, 7'd127, 1'b1);
      send_conversion(64'd123, MODE_NORMAL, 1'b0, 6'd0, 1'b0, CHAR_PLUS, 7'd64, 1'b0);
      // ordinary cases
      send_conversion(64'd1, MODE_NORMAL, 1'b1, 6'd0, 1'b0, CHAR_PLUS, 7'd0, 1'b0);
      send_conversion(-64'd1, MODE_SHORT, 1'b0, 6'h2a, 1'b0, CHAR_PLUS, 7'd0, 1'b0);
      send_conversion(64'd9, MODE_NORMAL, 1'b0, 6'd0, 1'b1, 8'hff, 7'd4, 1'b1);
      send_conversion(64'd0, MODE_NORMAL, 1'b0, 6'd0, 1'b0, 8'h00, 7'd0, 1'b0);
      send_conversion(-64'd5, MODE_NORMAL, 1'b0, 6'd0, 1'b1, CHAR_PLUS, 7'd0, 1'b0);
      send_conversion(64'd100, MODE_LONG, 1'b1, 6'd2, 1'b1, CHAR_BLANK, 7'd6, 1'b1);

      repeat (RANDOM_ITEMS) begin
         if ($urandom_range(0, 24) == 0) src_steady = !src_steady;
         send_random_conversion();
      end
      req_tvalid <= 1'b0;
      @(posedge clock);

      while (chars_pending != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== signed_decimal_formatter_top.f =====
hdl/sdf_pkg.sv
hdl/sdf_digit_unit.sv
hdl/signed_decimal_formatter_top.sv
test/sdf_char_checker.sv
test/tb_signed_decimal_formatter_top.sv
